// ===== rtl/core/assert_macros.svh =====
// Assertion helpers; they sample on clk and are off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ssm_pkg.sv =====
`default_nettype none
package ssm_pkg;
  localparam int FRAME_SIZE = 512;
  localparam int HALF_BINS  = FRAME_SIZE / 2 + 1;
  localparam int BIN_W      = 9;
  localparam int ADDR_W     = $clog2(HALF_BINS);
  localparam int GAIN_W     = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA = 1'b0,
    CFG_EPS   = 1'b1
  } cfg_idx_t;

  localparam logic [15:0] ALPHA_RST = 16'h8000;
  localparam logic [31:0] EPS_RST   = 32'd1;
endpackage
`default_nettype wire

// ===== rtl/core/ssm_in_if.sv =====
`default_nettype none
interface ssm_in_if;
  logic                       valid;
  logic                       ready;
  logic [ssm_pkg::BIN_W-1:0]  bin;
  logic signed [15:0]         x_real;
  logic signed [15:0]         x_imag;
  logic [31:0]                noise;

  modport source (output valid, bin, x_real, x_imag, noise, input ready);
  modport sink   (input valid, bin, x_real, x_imag, noise, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ssm_out_if.sv =====
`default_nettype none
interface ssm_out_if;
  logic                       valid;
  logic                       ready;
  logic [ssm_pkg::BIN_W-1:0]  out_bin;
  logic [15:0]                mask;
  logic [31:0]                snr;

  modport source (output valid, out_bin, mask, snr, input ready);
  modport sink   (input valid, out_bin, mask, snr, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ssm_ram.sv =====
`default_nettype none
module ssm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 257
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/spectral_snr_mask_top.sv =====
`default_nettype none
// Decision-directed a-priori SNR and Wiener gain, one frequency bin per word.
// The block takes one word per cycle unless the output is held, the gain RAM is
// being cleared or the word's bin is busy. The path is a fixed pipeline of power,
// weight and product stages, then a 32-stage restoring divider for xi and a
// 16-stage one for the gain, one quotient bit per stage. Per-bin gains live in a
// 257-entry RAM. After reset, a clearing pass writes every entry to zero, and
// input is held off until it is done. A word whose in-range bin still has an
// earlier word in flight is held off until that earlier word writes its gain
// back. When the output is held, words keep entering until the pipeline's last
// stage is occupied.
module spectral_snr_mask_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  ssm_in_if.sink                             in_s,
  ssm_out_if.source                          out_s,
  input  wire logic                          cfg_we,
  input  wire logic [ssm_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [ssm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ssm_pkg::*;
`include "assert_macros.svh"

  localparam int S_DIV1 = 5;            // stage holding divider 1 inputs
  localparam int S_XI   = S_DIV1 + 33;  // xi stage
  localparam int LAST   = S_XI + 16;    // gain ready

  logic [15:0] alpha_r;
  logic [31:0] eps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ALPHA_RST;
      eps_r   <= EPS_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_ALPHA: alpha_r <= cfg_data[15:0];
        CFG_EPS:   eps_r   <= cfg_data;
        default:   ;
      endcase
    end
  end

  // pipeline control
  logic             vld_r [LAST+1];
  logic [BIN_W-1:0] bin_r [LAST+1];
  logic             inr_r [LAST+1];
  logic             out_vld_r, out_vld_nxt;
  logic             en, acc, in_inr, pend_hit, wb;
  logic [LAST:0]    hit_w;
  logic [ADDR_W-1:0] in_addr, wb_addr;
  logic             clr_r;
  logic [ADDR_W-1:0] clr_addr_r;

  // a bin is busy while any stage holds an in-range word for it
  always_comb begin
    for (int s = 0; s <= LAST; s++) begin
      hit_w[s] = vld_r[s] && inr_r[s] && (bin_r[s] == in_s.bin);
    end
  end

  assign en       = !vld_r[LAST] || !out_vld_r || out_s.ready;
  assign in_inr   = in_s.bin < BIN_W'(HALF_BINS);
  assign in_addr  = in_s.bin[ADDR_W-1:0];
  assign pend_hit = in_inr && (|hit_w);
  assign in_s.ready = en && !pend_hit && !clr_r;
  assign acc      = in_s.valid && in_s.ready;
  assign wb       = en && vld_r[LAST] && inr_r[LAST];
  assign wb_addr  = bin_r[LAST][ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= LAST; s++) vld_r[s] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= acc;
      for (int s = 1; s <= LAST; s++) vld_r[s] <= vld_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bin_r[0] <= in_s.bin;
      inr_r[0] <= in_inr;
      for (int s = 1; s <= LAST; s++) begin
        bin_r[s] <= bin_r[s-1];
        inr_r[s] <= inr_r[s-1];
      end
    end
  end

  // clearing pass over the gain RAM after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == ADDR_W'(HALF_BINS - 1)) begin
        clr_r <= 1'b0;
      end
    end
  end

  logic [GAIN_W-1:0] ram_q;
  logic [GAIN_W-1:0] gn_w;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [GAIN_W-1:0] ram_wdata;

  assign ram_we    = wb || clr_r;
  assign ram_waddr = clr_r ? clr_addr_r : wb_addr;
  assign ram_wdata = clr_r ? '0 : gn_w;

  ssm_ram #(.WIDTH(GAIN_W), .DEPTH(HALF_BINS)) u_gain (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (en),
    .raddr (in_addr),
    .rdata (ram_q)
  );

  // stage 0: capture
  logic signed [15:0] xr_r, xq_r;
  logic [31:0]        noise_r;
  logic               gv_r;
  always_ff @(posedge clk) begin
    if (en) begin
      xr_r    <= in_s.x_real;
      xq_r    <= in_s.x_imag;
      noise_r <= in_s.noise;
      gv_r    <= in_inr;
    end
  end

  // stage 1: squares, g^2, denominator
  logic [31:0] sqr_r, sqi_r, gg_r;
  logic [32:0] den_r;
  logic [15:0] g_w;
  logic [32:0] den_w;
  assign g_w   = gv_r ? ram_q : 16'd0;
  assign den_w = {1'b0, noise_r} + {1'b0, eps_r};
  always_ff @(posedge clk) begin
    if (en) begin
      sqr_r <= 32'(xr_r * xr_r);
      sqi_r <= 32'(xq_r * xq_r);
      gg_r  <= 32'(g_w) * 32'(g_w);
      den_r <= (den_w == 33'd0) ? 33'd1 : den_w;
    end
  end

  // stage 2: power and weighted g^2
  logic [31:0] x2_r;
  logic [48:0] wm_r;
  logic [32:0] den2_r;
  logic [16:0] oma_w;
  assign oma_w = 17'h10000 - {1'b0, alpha_r};
  always_ff @(posedge clk) begin
    if (en) begin
      x2_r   <= sqr_r + sqi_r;
      wm_r   <= 49'(oma_w) * 49'(gg_r);
      den2_r <= den_r;
    end
  end

  // stage 3: weight w in Q0.32
  logic [31:0] x2b_r;
  logic [32:0] w_r;
  logic [32:0] den3_r;
  always_ff @(posedge clk) begin
    if (en) begin
      x2b_r  <= x2_r;
      w_r    <= 33'(wm_r >> 16) + {1'b0, alpha_r, 16'd0};
      den3_r <= den2_r;
    end
  end

  // stage 4: numerator and scaled divisor
  logic [63:0] n_r;
  logic [48:0] dd_r;
  always_ff @(posedge clk) begin
    if (en) begin
      n_r  <= 64'(65'(x2b_r) * 65'(w_r));
      dd_r <= {den3_r, 16'd0};
    end
  end

  // stage 5 onward: divider for xi, one quotient bit per stage
  logic [63:0] rem1_r [33];
  logic [48:0] d1_r   [33];
  logic [31:0] q1_r   [33];
  logic        sat_r  [33];

  always_ff @(posedge clk) begin
    if (en) begin
      rem1_r[0] <= n_r;
      d1_r[0]   <= dd_r;
      q1_r[0]   <= 32'd0;
      sat_r[0]  <= {17'd0, n_r[63:32]} >= dd_r;
    end
  end

  for (genvar k = 0; k < 32; k++) begin : g_div1
    localparam int SH = 31 - k;
    logic [80:0] dsh;
    logic        take;
    assign dsh  = {32'd0, d1_r[k]} << SH;
    assign take = {17'd0, rem1_r[k]} >= dsh;
    always_ff @(posedge clk) begin
      if (en) begin
        rem1_r[k+1] <= take ? rem1_r[k] - dsh[63:0] : rem1_r[k];
        q1_r[k+1]   <= {q1_r[k][30:0], take};
        d1_r[k+1]   <= d1_r[k];
        sat_r[k+1]  <= sat_r[k];
      end
    end
  end

  // xi stage and gain divider
  logic [47:0] rem2_r [17];
  logic [32:0] d2_r   [17];
  logic [15:0] q2_r   [17];
  logic [31:0] xi_r   [17];
  logic [31:0] xi_w;
  assign xi_w = sat_r[32] ? 32'hFFFF_FFFF : q1_r[32];

  always_ff @(posedge clk) begin
    if (en) begin
      xi_r[0]   <= xi_w;
      rem2_r[0] <= {xi_w, 16'd0};
      d2_r[0]   <= {1'b0, xi_w} + 33'h1_0000;
      q2_r[0]   <= 16'd0;
    end
  end

  for (genvar k = 0; k < 16; k++) begin : g_div2
    localparam int SH = 15 - k;
    logic [48:0] dsh;
    logic        take;
    assign dsh  = {16'd0, d2_r[k]} << SH;
    assign take = {1'b0, rem2_r[k]} >= dsh;
    always_ff @(posedge clk) begin
      if (en) begin
        rem2_r[k+1] <= take ? rem2_r[k] - dsh[47:0] : rem2_r[k];
        q2_r[k+1]   <= {q2_r[k][14:0], take};
        d2_r[k+1]   <= d2_r[k];
        xi_r[k+1]   <= xi_r[k];
      end
    end
  end

  assign gn_w = q2_r[16];

  // output register
  logic [BIN_W-1:0] out_bin_r;
  logic [15:0]      mask_r;
  logic [31:0]      snr_r;

  always_comb begin
    if (en && vld_r[LAST]) begin
      out_vld_nxt = 1'b1;
    end else if (out_s.ready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en && vld_r[LAST]) begin
      out_bin_r <= bin_r[LAST];
      mask_r    <= gn_w;
      snr_r     <= xi_r[16];
    end
  end

  assign out_s.valid   = out_vld_r;
  assign out_s.out_bin = out_bin_r;
  assign out_s.mask    = mask_r;
  assign out_s.snr     = snr_r;

  `ASSERT_NOW(a_clr_hold, clr_r, !in_s.ready, "input ready during gain clearing")
  `ASSERT_NOW(a_clr_wb, clr_r, !wb, "gain writeback during gain clearing")
  `ASSERT_NOW(a_rdy_en, in_s.ready, en, "input ready while pipeline is stalled")
  `ASSERT_NEXT(a_out_load, en && vld_r[LAST], out_s.valid, "finished word not presented")
endmodule
`default_nettype wire

// ===== bench/spectral_snr_mask_top_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module spectral_snr_mask_top_tb;
  import ssm_pkg::*;

  typedef struct {
    logic [BIN_W-1:0] bin;
    logic [15:0]      mask;
    logic [31:0]      snr;
  } mask_word_t;

  class gain_tracker;
    logic [15:0]      alpha;
    logic [31:0]      eps;
    logic [15:0]      gain [HALF_BINS];
    mask_word_t       expected_q [$];
    int               errors;

    function void clear();
      alpha = ALPHA_RST;
      eps = EPS_RST;
      foreach (gain[i]) gain[i] = '0;
      expected_q.delete();
      errors = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // decision-directed update, applied in acceptance order
    function void note_input(logic [BIN_W-1:0] bin, logic signed [15:0] xr,
                             logic signed [15:0] xq, logic [31:0] noise);
      logic [63:0] x2, g, w, den, q, xi, gn;
      bit          in_range;
      mask_word_t  m;
      in_range = bin < HALF_BINS;
      x2 = 64'(longint'(xr) * longint'(xr)) + 64'(longint'(xq) * longint'(xq));
      g = in_range ? 64'(gain[bin]) : 64'd0;
      w = (((64'd65536 - 64'(alpha)) * (g * g)) >> 16) + (64'(alpha) << 16);
      den = 64'(noise) + 64'(eps);
      if (den == 0) den = 1;
      q = (x2 * w) / (den << 16);
      xi = (q > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : q;
      gn = (xi << 16) / (xi + 64'd65536);
      if (in_range) gain[bin] = gn[15:0];
      m.bin = bin;
      m.mask = gn[15:0];
      m.snr = xi[31:0];
      expected_q.push_back(m);
    endfunction

    task report(string what);
      errors++;
      $display("%0t mismatch: %s", $realtime, what);
    endtask

    task check_result(logic [BIN_W-1:0] bin, logic [15:0] mask, logic [31:0] snr);
      mask_word_t m;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected word bin=%0d mask=%h snr=%h", bin, mask, snr));
        return;
      end
      m = expected_q.pop_front();
      if (bin !== m.bin) report($sformatf("bin %0d, want %0d", bin, m.bin));
      if (mask !== m.mask)
        report($sformatf("bin %0d mask %h, want %h", m.bin, mask, m.mask));
      if (snr !== m.snr)
        report($sformatf("bin %0d snr %h, want %h", m.bin, snr, m.snr));
    endtask
  endclass

  logic clk, rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  ssm_in_if  in_s();
  ssm_out_if out_s();

  spectral_snr_mask_top DUT (
    .clk(clk), .rst_n(rst_n), .in_s(in_s), .out_s(out_s),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  gain_tracker tracker;
  bit no_idle;
  bit hold_req = 0;
  bit hold_done = 0;
  int idle_cycles = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver side
  initial begin
    int r;
    out_s.ready = 0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_s.ready <= 0;
        repeat (300) @(negedge clk);
        hold_done = 1;
      end else if (no_idle) begin
        out_s.ready <= 1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) out_s.ready <= 1;
        else if (r < 96) out_s.ready <= 0;
        else begin
          out_s.ready <= 0;
          repeat ($urandom_range(10, 40)) @(negedge clk);
        end
      end
    end
  end

  always @(posedge clk)
    if (rst_n && out_s.valid && out_s.ready)
      tracker.check_result(out_s.out_bin, out_s.mask, out_s.snr);

  // stall watchdog
  always @(posedge clk) begin
    if ((in_s.valid && in_s.ready) || (out_s.valid && out_s.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 3000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task send_word(logic [BIN_W-1:0] bin, logic signed [15:0] xr,
                 logic signed [15:0] xq, logic [31:0] noise);
    int gap;
    gap = 0;
    if (!no_idle) begin
      int r;
      r = $urandom_range(0, 99);
      if (r >= 97) gap = $urandom_range(20, 60);
      else if (r >= 75) gap = $urandom_range(1, 3);
    end
    @(negedge clk);
    if (gap > 0) begin
      in_s.valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_s.valid <= 1;
    in_s.bin <= bin;
    in_s.x_real <= xr;
    in_s.x_imag <= xq;
    in_s.noise <= noise;
    do @(posedge clk); while (!in_s.ready);
    tracker.note_input(bin, xr, xq, noise);
  endtask

  task drain();
    @(negedge clk);
    in_s.valid <= 0;
    while (tracker.pending() != 0) @(negedge clk);
  endtask

  task write_regs(logic [15:0] alpha, logic [31:0] eps);
    @(negedge clk);
    cfg_we <= 1;
    cfg_idx <= CFG_ALPHA;
    cfg_data <= {16'd0, alpha};
    @(negedge clk);
    cfg_idx <= CFG_EPS;
    cfg_data <= eps;
    @(negedge clk);
    cfg_we <= 0;
    tracker.alpha = alpha;
    tracker.eps = eps;
  endtask

  function logic signed [15:0] pick_x();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1, 2: return 16'(($urandom_range(0, 1) ? -1 : 1) * (1 << $urandom_range(0, 14)));
      3: return $urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF;
      default: return 16'($urandom_range(0, 4000)) - 16'sd2000;
    endcase
  endfunction

  task random_word();
    logic [BIN_W-1:0] bin;
    logic signed [15:0] xr, xq;
    logic [31:0] noise;
    logic [63:0] x2;
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) bin = BIN_W'($urandom_range(0, 7));
    else if (r < 82) bin = BIN_W'($urandom_range(0, 256));
    else if (r < 94) bin = BIN_W'($urandom_range(257, 511));
    else bin = $urandom_range(0, 1) ? 9'd256 : 9'd0;
    xr = pick_x();
    xq = pick_x();
    x2 = 64'(longint'(xr) * longint'(xr)) + 64'(longint'(xq) * longint'(xq));
    case ($urandom_range(0, 9))
      0: noise = $urandom;
      1: noise = 0;
      2: noise = 32'hFFFF_FFFF;
      3: noise = $urandom_range(0, 1 << $urandom_range(0, 30));
      default: noise = 32'(x2 >> $urandom_range(0, 12)) + $urandom_range(0, 15);
    endcase
    send_word(bin, xr, xq, noise);
  endtask

  initial begin
    logic [15:0] alphas [6];
    logic [31:0] epss [6];
    tracker = new();
    tracker.clear();
    rst_n = 0;
    cfg_we = 0;
    cfg_idx = CFG_ALPHA;
    cfg_data = '0;
    in_s.valid = 0;
    in_s.bin = '0;
    in_s.x_real = '0;
    in_s.x_imag = '0;
    in_s.noise = '0;
    no_idle = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed words at reset settings
    send_word(9'd0, 16'sh8000, 16'sh8000, 32'd0);
    send_word(9'd0, 16'sh8000, 16'sh8000, 32'd0);
    send_word(9'd256, 16'sh7FFF, 16'sh0000, 32'hFFFF_FFFF);
    send_word(9'd256, 16'sh4000, 16'shC000, 32'h1000_0000);
    send_word(9'd257, 16'sh7FFF, 16'sh7FFF, 32'd5);
    send_word(9'd511, 16'sh0001, 16'shFFFF, 32'd0);
    send_word(9'd1, 16'sh0000, 16'sh0000, 32'd0);
    send_word(9'd1, 16'sh0000, 16'sh0000, 32'hFFFF_FFFF);
    send_word(9'd2, 16'sh1000, 16'sh1000, 32'h0080_0000);
    send_word(9'd2, 16'sh1000, 16'sh1000, 32'h0080_0000);
    send_word(9'd2, 16'sh1000, 16'sh1000, 32'h0080_0000);
    send_word(9'd3, 16'shFFFF, 16'sh0001, 32'h0000_0001);
    send_word(9'd170, 16'sh5555, 16'shAAAA, 32'h5555_5555);
    send_word(9'd85, 16'shAAAA, 16'sh5555, 32'hAAAA_AAAA);
    drain();

    // zero denominator, then the other extremes of both registers
    write_regs(16'd0, 32'd0);
    send_word(9'd4, 16'sh2000, 16'sh0000, 32'd0);
    send_word(9'd4, 16'sh2000, 16'sh0000, 32'd0);
    send_word(9'd300, 16'sh0000, 16'sh0000, 32'd0);
    drain();
    write_regs(16'hFFFF, 32'hFFFF_FFFF);
    send_word(9'd4, 16'sh8000, 16'sh8000, 32'hFFFF_FFFF);
    send_word(9'd5, 16'sh8000, 16'sh8000, 32'd0);
    drain();

    alphas = '{16'd32768, 16'd0, 16'd65535, 16'd32768, 16'd6554, 16'd49152};
    epss = '{32'd1, 32'd1, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'd1000};
    for (int p = 0; p < 6; p++) begin
      write_regs(alphas[p], epss[p]);
      no_idle = (p == 4);
      for (int n = 0; n < 290; n++) begin
        if (p == 2 && n == 40) hold_req = 1;
        if (p == 3 && n == 150) drain();
        random_word();
      end
      drain();
    end

    repeat (100) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+rtl/core
rtl/core/ssm_pkg.sv
rtl/core/ssm_in_if.sv
rtl/core/ssm_out_if.sv
rtl/core/ssm_ram.sv
rtl/core/spectral_snr_mask_top.sv
bench/spectral_snr_mask_top_tb.sv
